>>> rtl/efrx_pkg.sv
// Shared definitions for the escaped frame receiver with XOR check.
// Holds register indexes, reset values, status codes and the byte class type.
// No dependencies.
package efrx_pkg;

   // Depth of the frame store unless the top level overrides it.
   localparam int STORE_DEPTH_DEF = 64;

   // Frame layout limits.
   localparam int MIN_FRAME   = 3;
   localparam int MAX_PAYLOAD = 62;

   // Configuration register indexes.
   localparam logic [1:0] REG_START_CODE   = 2'd0;
   localparam logic [1:0] REG_END_CODE     = 2'd1;
   localparam logic [1:0] REG_ESCAPE_CODE  = 2'd2;
   localparam logic [1:0] REG_PAYLOAD_SIZE = 2'd3;

   // Configuration reset values.
   localparam logic [7:0] START_CODE_RST   = 8'd2;
   localparam logic [7:0] END_CODE_RST     = 8'd3;
   localparam logic [7:0] ESCAPE_CODE_RST  = 8'd16;
   localparam logic [5:0] PAYLOAD_SIZE_RST = 6'd8;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_LEN   = 2'd2;
   localparam logic [1:0] ST_CHECK = 2'd3;

   // Which control codes a received byte matches.
   typedef struct packed {
      logic esc;
      logic start;
      logic stop;
   } efrx_class_type;

endpackage

>>> rtl/efrx_class.sv
// Byte classifier: compares a received byte against the control codes.
// Depends on efrx_pkg for the class struct.
module efrx_class (
   input  logic [7:0]              rx_byte,
   input  logic [7:0]              start_code,
   input  logic [7:0]              end_code,
   input  logic [7:0]              escape_code,
   output efrx_pkg::efrx_class_type cls
);
   import efrx_pkg::*;

   // Priority among matches is resolved by the sequencer.
   always_comb begin
      cls.esc   = (rx_byte == escape_code);
      cls.start = (rx_byte == start_code);
      cls.stop  = (rx_byte == end_code);
   end

endmodule

>>> rtl/efrx_seq.sv
// Frame sequencer: stores unescaped bytes, checks a closed frame and drains
// its payload through one registered read port. Depends on efrx_pkg.
module efrx_seq #(
   parameter int STORE_DEPTH = efrx_pkg::STORE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  efrx_pkg::efrx_class_type cls,
   input  logic [5:0]              payload_size,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast
);
   import efrx_pkg::*;

   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int AW = $clog2(STORE_DEPTH);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHK_RD = 3'd1;
   localparam logic [2:0] S_CHK    = 3'd2;
   localparam logic [2:0] S_RD     = 3'd3;
   localparam logic [2:0] S_LOAD   = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          in_frame_ff, in_frame_in;
   logic          esc_ff, esc_in;
   logic [7:0]    xor_ff, xor_in;
   logic [7:0]    last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [7:0]    mem [STORE_DEPTH];
   logic [7:0]    rdata_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          accept;
   logic          store_req;
   logic          store_full;
   logic          err_short, err_len, err_check;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign store_full = (count_ff == CW'(STORE_DEPTH));
   assign wr_addr    = count_ff[AW-1:0];

   // Frame checks, valid while the length byte sits in the read register.
   assign err_short = (count_ff < CW'(MIN_FRAME));
   assign err_len   = (payload_size > 6'(MAX_PAYLOAD))
                   || (rdata_ff != {2'b00, payload_size})
                   || (9'(count_ff) != 9'(payload_size) + 9'd2);
   assign err_check = ((xor_ff ^ last_ff) != last_ff);

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      in_frame_in   = in_frame_ff;
      esc_in        = esc_ff;
      xor_in        = xor_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      store_req     = 1'b0;
      wr_en         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (esc_ff) begin
                  esc_in    = 1'b0;
                  store_req = in_frame_ff;
               end else if (cls.esc) begin
                  esc_in = 1'b1;
               end else if (cls.start) begin
                  in_frame_in = 1'b1;
                  count_in    = '0;
                  xor_in      = '0;
               end else if (in_frame_ff) begin
                  if (cls.stop) begin
                     in_frame_in = 1'b0;
                     idx_in      = '0;
                     state_in    = S_CHK_RD;
                  end else begin
                     store_req = 1'b1;
                  end
               end
            end
            // A byte that finds the store full drops the frame.
            if (store_req) begin
               if (store_full) begin
                  in_frame_in = 1'b0;
                  count_in    = '0;
                  xor_in      = '0;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  xor_in   = xor_ff ^ req_tdata;
                  last_in  = req_tdata;
               end
            end
         end
         S_CHK_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            count_in = '0;
            xor_in   = '0;
            if (err_short || err_len || err_check) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = err_short ? ST_SHORT : (err_len ? ST_LEN : ST_CHECK);
               state_in      = S_OUT;
            end else begin
               idx_in   = CW'(1);
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = rdata_ff;
            rsp_status_in = ST_OK;
            rsp_last_in   = (9'(idx_ff) == 9'(payload_size));
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         in_frame_ff  <= 1'b0;
         esc_ff       <= 1'b0;
         xor_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         in_frame_ff  <= in_frame_in;
         esc_ff       <= esc_in;
         xor_ff       <= xor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Frame store with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_tdata;
      end
      rdata_ff <= mem[idx_ff[AW-1:0]];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A pending word is only ever presented from the output state.
   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_OUT))
      else $error("result word valid outside the output state");

   // Input is never taken while a result word waits.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input ready while a result word is pending");

   // The stored byte count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STORE_DEPTH))
      else $error("byte count beyond store depth");

   // A load always produces a result word in the next cycle.
   a_load_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |=> rsp_valid_ff)
      else $error("load state did not present a result word");

   // An error word always closes the run.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> rsp_last_ff)
      else $error("error word without last mark");

endmodule

>>> rtl/escaped_frame_receiver_xor_check_core.sv
// A non-end byte is taken while idle and the block is ready again next cycle. An end
// byte starts a check through the store read port in S_CHK_RD and S_CHK; an error word
// is registered in S_CHK and shown in S_OUT, each payload word passes S_RD, S_LOAD and
// S_OUT, held there by an output stall; no input is taken until the last word is taken.
// Reset is synchronous and clears control state and registers; the store is not cleared.
module escaped_frame_receiver_xor_check_core #(
   parameter int STORE_DEPTH = efrx_pkg::STORE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [1:0] status
   output logic       rsp_tlast,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import efrx_pkg::*;

   logic [7:0]     start_ff, start_in;
   logic [7:0]     end_ff, end_in;
   logic [7:0]     escape_ff, escape_in;
   logic [5:0]     size_ff, size_in;
   efrx_class_type cls;

   // Configuration register writes.
   always_comb begin
      start_in  = start_ff;
      end_in    = end_ff;
      escape_in = escape_ff;
      size_in   = size_ff;
      if (csr_we) begin
         case (csr_index)
            REG_START_CODE:   start_in  = csr_wdata;
            REG_END_CODE:     end_in    = csr_wdata;
            REG_ESCAPE_CODE:  escape_in = csr_wdata;
            REG_PAYLOAD_SIZE: size_in   = csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= START_CODE_RST;
         end_ff    <= END_CODE_RST;
         escape_ff <= ESCAPE_CODE_RST;
         size_ff   <= PAYLOAD_SIZE_RST;
      end else begin
         start_ff  <= start_in;
         end_ff    <= end_in;
         escape_ff <= escape_in;
         size_ff   <= size_in;
      end
   end

   efrx_class u_class (
      .rx_byte     (req_tdata),
      .start_code  (start_ff),
      .end_code    (end_ff),
      .escape_code (escape_ff),
      .cls         (cls)
   );

   efrx_seq #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .cls          (cls),
      .payload_size (size_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
